// ===== sv/csp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants of the charstring path decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

  localparam int unsigned STACK_DEPTH = 48;
  localparam int unsigned STK_AW      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // segment kinds
  localparam logic [2:0] KIND_MOVE  = 3'd0;
  localparam logic [2:0] KIND_LINE  = 3'd1;
  localparam logic [2:0] KIND_CURVE = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_SUBR  = 2'd3;

  // charstring bytes
  localparam logic [7:0] OP_VMOVETO   = 8'd4;
  localparam logic [7:0] OP_RLINETO   = 8'd5;
  localparam logic [7:0] OP_HLINETO   = 8'd6;
  localparam logic [7:0] OP_VLINETO   = 8'd7;
  localparam logic [7:0] OP_RRCURVETO = 8'd8;
  localparam logic [7:0] OP_CALLSUBR  = 8'd10;
  localparam logic [7:0] OP_RETURN    = 8'd11;
  localparam logic [7:0] OP_ESCAPE    = 8'd12;
  localparam logic [7:0] OP_ENDCHAR   = 8'd14;
  localparam logic [7:0] OP_RMOVETO   = 8'd21;
  localparam logic [7:0] OP_HMOVETO   = 8'd22;
  localparam logic [7:0] OP_SHORTINT  = 8'd28;
  localparam logic [7:0] OP_CALLGSUBR = 8'd29;

  localparam logic [7:0] NUM1_LO   = 8'd32;
  localparam logic [7:0] NUM1_HI   = 8'd246;
  localparam logic [7:0] NUM1_BIAS = 8'd139;
  localparam logic [7:0] NUM2P_LO  = 8'd247;
  localparam logic [7:0] NUM2P_HI  = 8'd250;
  localparam logic [7:0] NUM2N_LO  = 8'd251;
  localparam logic [7:0] NUM2N_HI  = 8'd254;
  localparam logic [7:0] NUM2_BIAS = 8'd108;
  localparam logic [7:0] NUM_FIXED = 8'd255;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       glyph_start;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         segment_kind;
    logic [1:0]         error_code;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] ctrl1_x;
    logic signed [31:0] ctrl1_y;
    logic signed [31:0] ctrl2_x;
    logic signed [31:0] ctrl2_y;
    logic               last_of_run;
  } out_req_t;

  // number decoder status for the byte being accepted
  typedef struct packed {
    logic        consumed;
    logic        push;
    logic [31:0] value;
  } dec_t;

endpackage

`default_nettype wire

// ===== sv/csp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 48
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/csp_numdec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_numdec
// Number assembler: tracks prefix bytes and builds 16.16 operand values.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_numdec (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                fire_i,
  input  csp_pkg::in_req_t   req_i,
  output csp_pkg::dec_t      dec_o
);

  logic [7:0]  pref_q, pref_d, pref_e;
  logic [2:0]  pend_q, pend_d, pend_e;
  logic [31:0] part_q, part_d, part_e;
  logic [31:0] part_sh;
  logic [7:0]  b;
  logic [7:0]  p_off, n_off;
  logic [10:0] pos_mag, neg_mag;
  logic [15:0] neg_val, one_val;

  assign b       = req_i.code_byte;
  assign pref_e  = req_i.glyph_start ? 8'd0  : pref_q;
  assign pend_e  = req_i.glyph_start ? 3'd0  : pend_q;
  assign part_e  = req_i.glyph_start ? 32'd0 : part_q;
  assign part_sh = {part_e[23:0], b};

  assign p_off   = pref_e - csp_pkg::NUM2P_LO;
  assign n_off   = pref_e - csp_pkg::NUM2N_LO;
  assign pos_mag = {1'b0, p_off[1:0], b} + {3'd0, csp_pkg::NUM2_BIAS};
  assign neg_mag = {1'b0, n_off[1:0], b} + {3'd0, csp_pkg::NUM2_BIAS};
  assign neg_val = 16'd0 - {5'd0, neg_mag};
  assign one_val = {8'd0, b} - {8'd0, csp_pkg::NUM1_BIAS};

  always_comb begin
    dec_o  = '0;
    pref_d = pref_e;
    pend_d = pend_e;
    part_d = part_e;
    if (pend_e != 3'd0) begin
      dec_o.consumed = 1'b1;
      part_d = part_sh;
      pend_d = pend_e - 3'd1;
      if (pend_e == 3'd1) begin
        pref_d = 8'd0;
        part_d = 32'd0;
        dec_o.push = (pref_e != csp_pkg::OP_ESCAPE);
        if (pref_e inside {[csp_pkg::NUM2P_LO:csp_pkg::NUM2P_HI]}) begin
          dec_o.value = {5'd0, pos_mag, 16'h0};
        end else if (pref_e inside {[csp_pkg::NUM2N_LO:csp_pkg::NUM2N_HI]}) begin
          dec_o.value = {neg_val, 16'h0};
        end else if (pref_e == csp_pkg::OP_SHORTINT) begin
          dec_o.value = {part_sh[15:0], 16'h0};
        end else begin
          dec_o.value = part_sh;
        end
      end
    end else if (b inside {[csp_pkg::NUM1_LO:csp_pkg::NUM1_HI]}) begin
      dec_o.consumed = 1'b1;
      dec_o.push     = 1'b1;
      dec_o.value    = {one_val, 16'h0};
    end else if (b >= csp_pkg::NUM2P_LO) begin
      dec_o.consumed = 1'b1;
      pref_d = b;
      part_d = 32'd0;
      pend_d = (b == csp_pkg::NUM_FIXED) ? 3'd4 : 3'd1;
    end else if (b == csp_pkg::OP_SHORTINT) begin
      dec_o.consumed = 1'b1;
      pref_d = b;
      part_d = 32'd0;
      pend_d = 3'd2;
    end else if (b == csp_pkg::OP_ESCAPE) begin
      // operator itself clears the stack; the next byte is dropped
      pref_d = b;
      pend_d = 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pref_q <= 8'd0;
      pend_q <= 3'd0;
      part_q <= 32'd0;
    end else if (fire_i) begin
      pref_q <= pref_d;
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/charstring_path_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charstring_path_decoder
// Type 2 charstring interpreter emitting moveto, lineto, curveto segments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_req_i) takes one charstring
//   byte per request; glyph_start clears point, stack and pending number.
//   Output channel (out_valid_o / out_ready_i / out_req_o) carries one path
//   segment, end-of-glyph or error per request; last_of_run marks the final
//   result caused by a byte.
//   Number and ignored bytes are handled in the idle state. A byte with a
//   single result (endchar, subroutine, underflow, overflow) goes through
//   the emit state. Drawing operators walk the operand stack RAM through
//   its one read port: the first read is issued when the byte is accepted,
//   then the operands are read in stack order; curves emit every six
//   operands, lines every one or two.
//   Results go to an output register; a stalled receiver holds the walk at
//   the next result, and further bytes wait until the walk is done.
//   Reset clears point, count and decoder state; stack contents stay
//   undefined and are only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module charstring_path_decoder (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  csp_pkg::in_req_t    in_req_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output csp_pkg::out_req_t   out_req_o
);

  localparam int unsigned AW = csp_pkg::STK_AW;
  localparam int unsigned CW = csp_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EMIT1 = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_WALK = 3'd1;
  localparam logic [2:0] CLS_END  = 3'd2;
  localparam logic [2:0] CLS_SUBR = 3'd3;
  localparam logic [2:0] CLS_ESC  = 3'd4;

  localparam logic [2:0] AX_ALT  = 3'd0;
  localparam logic [2:0] AX_X    = 3'd1;
  localparam logic [2:0] AX_Y    = 3'd2;
  localparam logic [2:0] AX_IDX  = 3'd3;
  localparam logic [2:0] AX_IDXN = 3'd4;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] c);
    logic signed [32:0] s;
    s = {a[31], a} + {c[31], c};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d, cnt_e;
  logic [CW-1:0]      idx_q, idx_d;
  logic [2:0]         j_q, j_d;
  logic [2:0]         g_q, g_d;
  logic [2:0]         axis_q, axis_d;
  logic [2:0]         kind_q, kind_d;
  logic [1:0]         err_q, err_d;
  logic signed [31:0] px_q, px_d, py_q, py_d;
  logic signed [31:0] c1x_q, c1x_d, c1y_q, c1y_d, c2x_q, c2x_d, c2y_q, c2y_d;
  logic               out_valid_q;
  csp_pkg::out_req_t  out_q, out_d;
  logic               out_load;

  logic               in_fire, out_free;
  csp_pkg::dec_t      dec;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        rdata;

  logic [2:0]         cls, op_g, op_axis, op_kind;
  logic [CW-1:0]      op_st;
  logic               axis_x, grp_end, cont, go;
  logic [CW:0]        nxt;
  logic signed [31:0] opnd, acc, sum;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign cnt_e       = in_req_i.glyph_start ? '0 : cnt_q;

  csp_numdec u_numdec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .req_i  (in_req_i),
    .dec_o  (dec)
  );

  csp_ram #(
    .WIDTH (32),
    .DEPTH (csp_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (dec.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // operator classification
  always_comb begin
    cls     = CLS_NONE;
    op_g    = 3'd1;
    op_axis = AX_ALT;
    op_kind = csp_pkg::KIND_MOVE;
    op_st   = '0;
    case (in_req_i.code_byte)
      csp_pkg::OP_RMOVETO: begin
        cls   = CLS_WALK;
        op_g  = 3'd2;
        op_st = cnt_e - CW'(2);
      end
      csp_pkg::OP_HMOVETO: begin
        cls     = CLS_WALK;
        op_axis = AX_X;
        op_st   = cnt_e - CW'(1);
      end
      csp_pkg::OP_VMOVETO: begin
        cls     = CLS_WALK;
        op_axis = AX_Y;
        op_st   = cnt_e - CW'(1);
      end
      csp_pkg::OP_RLINETO: begin
        cls     = CLS_WALK;
        op_g    = 3'd2;
        op_kind = csp_pkg::KIND_LINE;
      end
      csp_pkg::OP_HLINETO: begin
        cls     = CLS_WALK;
        op_axis = AX_IDX;
        op_kind = csp_pkg::KIND_LINE;
      end
      csp_pkg::OP_VLINETO: begin
        cls     = CLS_WALK;
        op_axis = AX_IDXN;
        op_kind = csp_pkg::KIND_LINE;
      end
      csp_pkg::OP_RRCURVETO: begin
        cls     = CLS_WALK;
        op_g    = 3'd6;
        op_kind = csp_pkg::KIND_CURVE;
      end
      csp_pkg::OP_ENDCHAR:  cls = CLS_END;
      csp_pkg::OP_CALLSUBR,
      csp_pkg::OP_RETURN,
      csp_pkg::OP_CALLGSUBR: cls = CLS_SUBR;
      csp_pkg::OP_ESCAPE:   cls = CLS_ESC;
      default:              cls = CLS_NONE;
    endcase
  end

  // stack walk datapath
  always_comb begin
    case (axis_q)
      AX_ALT:  axis_x = !j_q[0];
      AX_X:    axis_x = 1'b1;
      AX_Y:    axis_x = 1'b0;
      AX_IDX:  axis_x = !idx_q[0];
      AX_IDXN: axis_x = idx_q[0];
      default: axis_x = 1'b1;
    endcase
  end

  assign opnd    = rdata;
  assign acc     = axis_x ? px_q : py_q;
  assign sum     = sat_add(acc, opnd);
  assign grp_end = (j_q == (g_q - 3'd1));
  assign nxt     = {1'b0, idx_q} + (CW + 1)'(1);
  assign cont    = ({1'b0, nxt} + (CW + 2)'(g_q)) <= (CW + 2)'(cnt_q);
  assign go      = !grp_end || out_free;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    j_d      = j_q;
    g_d      = g_q;
    axis_d   = axis_q;
    kind_d   = kind_q;
    err_d    = err_q;
    px_d     = px_q;
    py_d     = py_q;
    c1x_d    = c1x_q;
    c1y_d    = c1y_q;
    c2x_d    = c2x_q;
    c2y_d    = c2y_q;
    we       = 1'b0;
    waddr    = cnt_e[AW-1:0];
    re       = 1'b0;
    raddr    = op_st[AW-1:0];
    out_load = 1'b0;
    out_d    = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d = cnt_e;
          if (in_req_i.glyph_start) begin
            px_d = '0;
            py_d = '0;
          end
          if (dec.push) begin
            if (cnt_e >= CW'(csp_pkg::STACK_DEPTH)) begin
              state_d = ST_EMIT1;
              kind_d  = csp_pkg::KIND_ERR;
              err_d   = csp_pkg::ERR_OVER;
            end else begin
              we    = 1'b1;
              cnt_d = cnt_e + CW'(1);
            end
          end else if (!dec.consumed) begin
            case (cls)
              CLS_WALK: begin
                if (cnt_e < CW'(op_g)) begin
                  state_d = ST_EMIT1;
                  kind_d  = csp_pkg::KIND_ERR;
                  err_d   = csp_pkg::ERR_UNDER;
                  cnt_d   = '0;
                end else begin
                  re      = 1'b1;
                  idx_d   = op_st;
                  j_d     = 3'd0;
                  g_d     = op_g;
                  axis_d  = op_axis;
                  kind_d  = op_kind;
                  state_d = ST_WALK;
                end
              end
              CLS_END: begin
                state_d = ST_EMIT1;
                kind_d  = csp_pkg::KIND_END;
                err_d   = csp_pkg::ERR_NONE;
                cnt_d   = '0;
              end
              CLS_SUBR: begin
                state_d = ST_EMIT1;
                kind_d  = csp_pkg::KIND_ERR;
                err_d   = csp_pkg::ERR_SUBR;
                cnt_d   = '0;
              end
              CLS_ESC: cnt_d = '0;
              default: ;
            endcase
          end
        end
      end

      ST_EMIT1: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '0;
          out_d.segment_kind = kind_q;
          out_d.error_code   = err_q;
          out_d.end_x        = px_q;
          out_d.end_y        = py_q;
          out_d.last_of_run  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_WALK: begin
        if (go) begin
          if (axis_x) begin
            px_d = sum;
          end else begin
            py_d = sum;
          end
          if (kind_q == csp_pkg::KIND_CURVE) begin
            case (j_q)
              3'd0:    c1x_d = sum;
              3'd1:    c1y_d = sum;
              3'd2:    c2x_d = sum;
              3'd3:    c2y_d = sum;
              default: ;
            endcase
          end
          idx_d = nxt[CW-1:0];
          raddr = nxt[AW-1:0];
          if (grp_end) begin
            out_load = 1'b1;
            out_d    = '0;
            out_d.segment_kind = kind_q;
            out_d.error_code   = csp_pkg::ERR_NONE;
            out_d.end_x        = axis_x ? sum : px_q;
            out_d.end_y        = axis_x ? py_q : sum;
            if (kind_q == csp_pkg::KIND_CURVE) begin
              out_d.ctrl1_x = c1x_q;
              out_d.ctrl1_y = c1y_q;
              out_d.ctrl2_x = c2x_q;
              out_d.ctrl2_y = c2y_q;
            end
            out_d.last_of_run = !cont;
            j_d = 3'd0;
            if (cont) begin
              re = 1'b1;
            end else begin
              cnt_d   = '0;
              state_d = ST_IDLE;
            end
          end else begin
            j_d = j_q + 3'd1;
            re  = 1'b1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      px_q    <= px_d;
      py_q    <= py_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_d_reg: begin
      idx_q  <= idx_d;
      j_q    <= j_d;
      g_q    <= g_d;
      axis_q <= axis_d;
      kind_q <= kind_d;
      err_q  <= err_d;
      c1x_q  <= c1x_d;
      c1y_q  <= c1y_d;
      c2x_q  <= c2x_d;
      c2y_q  <= c2y_d;
      out_q  <= out_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/csp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_checker
// Port-level assertions for the charstring path decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_o,
  input csp_pkg::in_req_t   in_req_i,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input csp_pkg::out_req_t  out_req_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_req_o))
    else $error("output payload changed while stalled");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_req_o.segment_kind == csp_pkg::KIND_ERR) ==
                     (out_req_o.error_code != csp_pkg::ERR_NONE)))
    else $error("error code does not match segment kind");

  a_ctrl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.segment_kind != csp_pkg::KIND_CURVE) |->
      (out_req_o.ctrl1_x == 32'sd0) && (out_req_o.ctrl1_y == 32'sd0) &&
      (out_req_o.ctrl2_x == 32'sd0) && (out_req_o.ctrl2_y == 32'sd0))
    else $error("control points set on a non-curve segment");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_req_o.segment_kind == csp_pkg::KIND_ERR) ||
                    (out_req_o.segment_kind == csp_pkg::KIND_END))
      |-> out_req_o.last_of_run)
    else $error("single result not marked last");

endmodule

bind charstring_path_decoder csp_checker u_csp_checker (.*);

`default_nettype wire

// ===== tb/tb_charstring_path_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_charstring_path_decoder
// Self-checking bench for the Type 2 charstring path decoder. Bytes go in
// through a valid/ready channel with random gaps. A scoreboard decodes each
// accepted request into the path segments it should cause. Every segment
// that comes out is compared field by field against the oldest prediction.
// A directed opener covers the number encodings, every operator but rlineto,
// underflow, subroutine bytes, escape, glyph restart and saturation. A forced
// overflow runs while the receiver holds off for a long stretch. Random glyph
// programs with some noise bytes follow.
// ----------------------------------------------------------------------------

module tb_charstring_path_decoder;
  import csp_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES    = 64;
  localparam int unsigned RANDOM_ITEMS   = 120;
  localparam longint     SUM_MAX        = 64'sd2147483647;
  localparam longint     SUM_MIN        = -64'sd2147483648;

  class path_scoreboard;
    logic signed [31:0] operands [STACK_DEPTH];
    int unsigned        depth_used;
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;
    logic [7:0]         lead_byte;
    int unsigned        bytes_left;
    logic [31:0]        gathered;
    out_req_t           segments_due[$];
    out_req_t           held;
    bit                 have_held;
    int unsigned        mismatches;

    function new();
      depth_used = 0;
      pen_x      = '0;
      pen_y      = '0;
      lead_byte  = '0;
      bytes_left = 0;
      gathered   = '0;
      have_held  = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return segments_due.size() + (have_held ? 1 : 0);
    endfunction

    function logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > SUM_MAX) return 32'sh7fff_ffff;
      if (s < SUM_MIN) return 32'sh8000_0000;
      return s[31:0];
    endfunction

    function logic signed [31:0] to_fixed(int v);
      return {v[15:0], 16'h0000};
    endfunction

    // the last segment of a request is held back so it can be flagged
    function void add_segment(logic [2:0] kind, logic [1:0] code,
                              logic signed [31:0] c1x = 0, logic signed [31:0] c1y = 0,
                              logic signed [31:0] c2x = 0, logic signed [31:0] c2y = 0);
      out_req_t r;
      if (have_held) segments_due.push_back(held);
      r.segment_kind = kind;
      r.error_code   = code;
      r.end_x        = pen_x;
      r.end_y        = pen_y;
      r.ctrl1_x      = c1x;
      r.ctrl1_y      = c1y;
      r.ctrl2_x      = c2x;
      r.ctrl2_y      = c2y;
      r.last_of_run  = 1'b0;
      held           = r;
      have_held      = 1'b1;
    endfunction

    function void push_operand(logic signed [31:0] v);
      if (depth_used >= STACK_DEPTH) begin
        add_segment(KIND_ERR, ERR_OVER);
      end else begin
        operands[depth_used] = v;
        depth_used++;
      end
    endfunction

    function void note_request(in_req_t req);
      logic [7:0]         b;
      int                 p;
      int unsigned        c;
      int unsigned        i;
      bit                 keep_stack;
      logic signed [31:0] ax, ay, bx, by;
      b          = req.code_byte;
      keep_stack = 1'b0;
      if (req.glyph_start) begin
        depth_used = 0;
        pen_x      = '0;
        pen_y      = '0;
        lead_byte  = '0;
        bytes_left = 0;
        gathered   = '0;
      end
      if (bytes_left != 0) begin
        gathered = {gathered[23:0], b};
        bytes_left--;
        if (bytes_left == 0) begin
          p = int'(lead_byte);
          if (lead_byte >= NUM2P_LO && lead_byte <= NUM2P_HI) begin
            push_operand(to_fixed((p - int'(NUM2P_LO)) * 256 + int'(b) + int'(NUM2_BIAS)));
          end else if (lead_byte >= NUM2N_LO && lead_byte <= NUM2N_HI) begin
            push_operand(to_fixed(-(p - int'(NUM2N_LO)) * 256 - int'(b) - int'(NUM2_BIAS)));
          end else if (lead_byte == OP_SHORTINT) begin
            push_operand({gathered[15:0], 16'h0000});
          end else if (lead_byte == NUM_FIXED) begin
            push_operand(gathered);
          end
          lead_byte = '0;
          gathered  = '0;
        end
      end else if (b >= NUM1_LO && b <= NUM1_HI) begin
        push_operand(to_fixed(int'(b) - int'(NUM1_BIAS)));
      end else if (b >= NUM2P_LO) begin
        lead_byte  = b;
        gathered   = '0;
        bytes_left = (b == NUM_FIXED) ? 4 : 1;
      end else if (b == OP_SHORTINT) begin
        lead_byte  = b;
        gathered   = '0;
        bytes_left = 2;
      end else begin
        c = depth_used;
        case (b)
          OP_RMOVETO: begin
            if (c < 2) begin
              add_segment(KIND_ERR, ERR_UNDER);
            end else begin
              pen_x = sat_sum(pen_x, operands[c-2]);
              pen_y = sat_sum(pen_y, operands[c-1]);
              add_segment(KIND_MOVE, ERR_NONE);
            end
          end
          OP_HMOVETO, OP_VMOVETO: begin
            if (c < 1) begin
              add_segment(KIND_ERR, ERR_UNDER);
            end else begin
              if (b == OP_HMOVETO) pen_x = sat_sum(pen_x, operands[c-1]);
              else pen_y = sat_sum(pen_y, operands[c-1]);
              add_segment(KIND_MOVE, ERR_NONE);
            end
          end
          OP_RLINETO: begin
            if (c < 2) add_segment(KIND_ERR, ERR_UNDER);
            for (i = 0; i + 1 < c; i += 2) begin
              pen_x = sat_sum(pen_x, operands[i]);
              pen_y = sat_sum(pen_y, operands[i+1]);
              add_segment(KIND_LINE, ERR_NONE);
            end
          end
          OP_HLINETO, OP_VLINETO: begin
            if (c < 1) add_segment(KIND_ERR, ERR_UNDER);
            for (i = 0; i < c; i++) begin
              if (((i % 2) == 0) == (b == OP_HLINETO)) pen_x = sat_sum(pen_x, operands[i]);
              else pen_y = sat_sum(pen_y, operands[i]);
              add_segment(KIND_LINE, ERR_NONE);
            end
          end
          OP_RRCURVETO: begin
            if (c < 6) add_segment(KIND_ERR, ERR_UNDER);
            for (i = 0; i + 5 < c; i += 6) begin
              ax    = sat_sum(pen_x, operands[i]);
              ay    = sat_sum(pen_y, operands[i+1]);
              bx    = sat_sum(ax, operands[i+2]);
              by    = sat_sum(ay, operands[i+3]);
              pen_x = sat_sum(bx, operands[i+4]);
              pen_y = sat_sum(by, operands[i+5]);
              add_segment(KIND_CURVE, ERR_NONE, ax, ay, bx, by);
            end
          end
          OP_ENDCHAR: add_segment(KIND_END, ERR_NONE);
          OP_CALLSUBR, OP_RETURN, OP_CALLGSUBR: add_segment(KIND_ERR, ERR_SUBR);
          OP_ESCAPE: begin
            lead_byte  = OP_ESCAPE;
            bytes_left = 1;
          end
          default: keep_stack = 1'b1;
        endcase
        if (!keep_stack) depth_used = 0;
      end
      if (have_held) begin
        held.last_of_run = 1'b1;
        segments_due.push_back(held);
        have_held = 1'b0;
      end
    endfunction

    function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_segment(out_req_t got);
      out_req_t want;
      if (segments_due.size() == 0) begin
        $error("segment with no request waiting: kind %0d", got.segment_kind);
        mismatches++;
        return;
      end
      want = segments_due.pop_front();
      check_field("segment_kind", want.segment_kind, got.segment_kind);
      check_field("error_code", want.error_code, got.error_code);
      check_field("end_x", want.end_x, got.end_x);
      check_field("end_y", want.end_y, got.end_y);
      check_field("ctrl1_x", want.ctrl1_x, got.ctrl1_x);
      check_field("ctrl1_y", want.ctrl1_y, got.ctrl1_y);
      check_field("ctrl2_x", want.ctrl2_x, got.ctrl2_x);
      check_field("ctrl2_y", want.ctrl2_y, got.ctrl2_y);
      check_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_req_t     in_req    = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  out_req_t    out_req;

  path_scoreboard sb = new();

  int unsigned cycle_count   = 0;
  int          requests_sent = 0;
  int          tx_gap        = 1;
  bit          tx_steady     = 1'b0;
  bit          rx_steady     = 1'b0;
  bit          rx_hold_req   = 1'b0;

  charstring_path_decoder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_gap(bit steady);
    return steady ? 0 : int'($urandom_range(0, 15));
  endfunction

  // gap to the next request is drawn at acceptance so valid is only
  // dropped when a gap follows
  task automatic send_byte(logic [7:0] code, logic start);
    in_req_t req;
    req.code_byte   = code;
    req.glyph_start = start;
    if (tx_gap > 0) repeat (tx_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
    tx_gap = draw_gap(tx_steady);
    if (tx_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic drain_tx();
    if (tx_gap == 0) begin
      in_valid <= 1'b0;
      tx_gap = 1;
    end
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // optional noise, operands in mixed encodings, then one operator
  task automatic send_sequence();
    int         operand_total;
    int         pick;
    int         k;
    logic       gs;
    logic [7:0] op;
    tx_steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    gs   = ($urandom_range(0, 5) == 0);
    pick = $urandom_range(0, 19);
    if (pick < 14) operand_total = $urandom_range(0, 8);
    else if (pick < 19) operand_total = $urandom_range(6, 19);
    else operand_total = $urandom_range(44, 50);
    for (k = 0; k < operand_total; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_byte(8'($urandom_range(NUM1_LO, NUM1_HI)), gs);
      end else if (pick < 7) begin
        send_byte(8'($urandom_range(NUM2P_LO, NUM2N_HI)), gs);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 9) begin
        send_byte(OP_SHORTINT, gs);
        repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_byte(NUM_FIXED, gs);
        repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      gs = 1'b0;
    end
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      case ($urandom_range(0, 6))
        0: op = OP_RMOVETO;
        1: op = OP_HMOVETO;
        2: op = OP_VMOVETO;
        3: op = OP_RLINETO;
        4: op = OP_HLINETO;
        5: op = OP_VLINETO;
        default: op = OP_RRCURVETO;
      endcase
    end else if (pick < 15) begin
      op = OP_RRCURVETO;
    end else if (pick == 15) begin
      op = OP_ENDCHAR;
    end else if (pick == 16) begin
      case ($urandom_range(0, 2))
        0: op = OP_CALLSUBR;
        1: op = OP_RETURN;
        default: op = OP_CALLGSUBR;
      endcase
    end else if (pick == 17) begin
      send_byte(OP_ESCAPE, gs);
      gs = 1'b0;
      op = 8'($urandom_range(0, 255));
    end else begin
      case ($urandom_range(0, 5))
        0: op = 8'($urandom_range(0, 3));
        1: op = 8'd9;
        2: op = 8'd13;
        3: op = 8'($urandom_range(15, 20));
        4: op = 8'($urandom_range(23, 27));
        default: op = 8'($urandom_range(30, 31));
      endcase
    end
    send_byte(op, gs);
  endtask

  initial begin
    int rx_wait;
    @(posedge rst_ni);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_wait = RX_HOLD_CYCLES;
      end else begin
        rx_wait = draw_gap(rx_steady);
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        repeat (rx_wait) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_segment(out_req);
    end
  end

  initial begin
    int random_start;
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;

    send_byte(8'd0, 1'b1);
    send_byte(8'd32, 1'b0);
    send_byte(8'd246, 1'b0);
    send_byte(OP_RMOVETO, 1'b0);
    send_byte(OP_VMOVETO, 1'b0);
    send_byte(8'd250, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd251, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(OP_HLINETO, 1'b0);
    send_byte(OP_SHORTINT, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(OP_VLINETO, 1'b0);
    // escape swallows what would otherwise start a 16.16 number
    send_byte(OP_ESCAPE, 1'b0);
    send_byte(NUM_FIXED, 1'b0);
    send_byte(OP_RRCURVETO, 1'b0);
    send_byte(OP_CALLSUBR, 1'b0);
    send_byte(OP_RETURN, 1'b0);
    send_byte(OP_CALLGSUBR, 1'b0);
    send_byte(OP_ENDCHAR, 1'b0);
    send_byte(NUM_FIXED, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(OP_HMOVETO, 1'b0);
    // restart in the middle of a short int
    send_byte(OP_SHORTINT, 1'b0);
    send_byte(8'd1, 1'b1);
    drain_tx();

    // overflow the stack while the receiver holds off
    rx_hold_req = 1'b1;
    send_byte(8'd139, 1'b1);
    repeat (49) send_byte(8'($urandom_range(NUM1_LO, NUM1_HI)), 1'b0);
    send_byte(OP_RLINETO, 1'b0);

    random_start = requests_sent;
    while (requests_sent < random_start + RANDOM_ITEMS) send_sequence();
    drain_tx();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== charstring_path_decoder.f =====
sv/csp_pkg.sv
sv/csp_ram.sv
sv/csp_numdec.sv
sv/charstring_path_decoder.sv
sv/csp_checker.sv
tb/tb_charstring_path_decoder.sv
